### src/bm3_pkg.sv
// ============================================================================
// bm3_pkg
// Shared types, codes and constants of the 3x3 binary morphology filter.
// ============================================================================
`default_nettype none

package bm3_pkg;

    // Configuration register widths and reset values.
    localparam int CFG_W         = 11;
    localparam int SHAPE_W       = 2;
    localparam int CFG_INDEX_W   = 2;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [CFG_W-1:0] MIN_FRAME_DIM    = 11'd3;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Window layout: top row bits 8..6, middle 5..3, bottom 2..0.
    localparam logic [8:0] ROW_SHIFT_KEEP  = 9'h1B6;
    localparam logic [8:0] MASK_VERTICAL   = 9'h092;
    localparam logic [8:0] MASK_HORIZONTAL = 9'h038;
    localparam logic [8:0] MASK_FOUR       = 9'h0BA;
    localparam logic [8:0] MASK_EIGHT      = 9'h1FF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_KERNEL_SHAPE = 2'd2,
        REG_OPERATION    = 2'd3
    } reg_index_t;

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_VERTICAL   = 2'd0,
        SHAPE_HORIZONTAL = 2'd1,
        SHAPE_FOUR       = 2'd2,
        SHAPE_EIGHT      = 2'd3
    } kernel_shape_t;

    typedef enum logic {
        OP_ERODE  = 1'b0,
        OP_DILATE = 1'b1
    } operation_t;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } action_t;

    // One work entry handed from the front to the back.
    typedef struct packed {
        logic       update;   // shift a new column into the window
        logic       emit;     // produce one output pixel
        logic       px;       // newest pixel
        logic [1:0] stored;   // line store bits: [1] two rows up, [0] one row up
    } bm3_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bm3_qstat_t;

    function automatic logic [8:0] shape_mask(input kernel_shape_t shape);
        logic [8:0] m;
        case (shape)
            SHAPE_VERTICAL:   m = MASK_VERTICAL;
            SHAPE_HORIZONTAL: m = MASK_HORIZONTAL;
            SHAPE_FOUR:       m = MASK_FOUR;
            SHAPE_EIGHT:      m = MASK_EIGHT;
            default:          m = MASK_EIGHT;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### src/bm3_front.sv
// ============================================================================
// bm3_front
// Accepts input beats, tracks the input raster position and the count of
// pixels still owed an output, and reads and updates the two-row line store.
// ============================================================================
`default_nettype none

module bm3_front
    import bm3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire action_t          in_action,
    input  wire logic             in_pixel,
    input  wire logic [CFG_W-1:0] eff_width,
    input  wire logic [CFG_W-1:0] eff_height,
    input  wire bm3_qstat_t       q_stat,
    output logic                  q_push,
    output bm3_entry_t            q_entry
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PEND_W = $clog2(MAX_WIDTH + 3);
    localparam int MAX_AB = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int MAX_CD = (PEND_W > CFG_W) ? PEND_W : CFG_W;
    localparam int CMP_W  = ((MAX_AB > MAX_CD) ? MAX_AB : MAX_CD) + 2;

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              f_valid_reg, f_valid_next;

    logic              f_update_reg, f_emit_reg, f_px_reg;
    logic [COL_W-1:0]  f_col_reg;
    logic [1:0]        rd_data_reg;
    logic [1:0]        line_store [MAX_WIDTH];

    logic accept, is_pixel, col_last, row_last, pix_emit, flush_emit;

    assign in_ready = !f_valid_reg || !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign q_push   = f_valid_reg && !q_stat.full;
    assign is_pixel = (in_action == ACT_PIXEL);

    assign col_last   = (CMP_W'(in_col_reg) + CMP_W'(1)) >= CMP_W'(eff_width);
    assign row_last   = (CMP_W'(in_row_reg) + CMP_W'(1)) >= CMP_W'(eff_height);
    assign pix_emit   = CMP_W'(pend_reg) > CMP_W'(eff_width);
    assign flush_emit = (in_col_reg == '0) && (in_row_reg == '0) && (pend_reg != '0);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        pend_next    = pend_reg;
        f_valid_next = f_valid_reg;
        if (q_push)
        begin
            f_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (is_pixel)
            begin
                if (col_last)
                begin
                    in_col_next = '0;
                    in_row_next = row_last ? '0 : in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (!pix_emit)
                begin
                    pend_next = pend_reg + PEND_W'(1);
                end
                f_valid_next = 1'b1;
            end
            else if (flush_emit)
            begin
                pend_next    = pend_reg - PEND_W'(1);
                f_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            pend_reg    <= '0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            pend_reg    <= pend_next;
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_update_reg <= is_pixel;
            f_emit_reg   <= is_pixel ? pix_emit : flush_emit;
            f_px_reg     <= in_pixel;
            f_col_reg    <= in_col_reg;
        end
    end

    // Line store: read when a pixel is taken, written back when it moves on.
    always_ff @(posedge clk)
    begin
        if (accept && is_pixel)
        begin
            rd_data_reg <= line_store[in_col_reg];
        end
        if (q_push && f_update_reg)
        begin
            line_store[f_col_reg] <= {rd_data_reg[0], f_px_reg};
        end
    end

    assign q_entry.update = f_update_reg;
    assign q_entry.emit   = f_emit_reg;
    assign q_entry.px     = f_px_reg;
    assign q_entry.stored = rd_data_reg;

endmodule

`default_nettype wire

### src/bm3_queue.sv
// ============================================================================
// bm3_queue
// Small register queue that decouples the front from the back.
// ============================================================================
`default_nettype none

module bm3_queue
    import bm3_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire bm3_entry_t push_data,
    input  wire logic       pop,
    output bm3_entry_t      head,
    output bm3_qstat_t      stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bm3_entry_t       slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### src/bm3_back.sv
// ============================================================================
// bm3_back
// Shifts columns into the 3x3 window, tracks the output raster position and
// evaluates erosion or dilation into the output register.
// ============================================================================
`default_nettype none

module bm3_back
    import bm3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bm3_entry_t       head,
    input  wire bm3_qstat_t       q_stat,
    output logic                  pop,
    input  wire logic [CFG_W-1:0] eff_width,
    input  wire logic [CFG_W-1:0] eff_height,
    input  wire kernel_shape_t    shape,
    input  wire operation_t       op,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  out_pixel,
    output logic                  out_last
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int MAX_AB = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W  = ((MAX_AB > CFG_W) ? MAX_AB : CFG_W) + 2;

    logic [8:0]       window_reg, window_next, win_cur, mask, sel;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_pixel_reg, out_last_reg;
    logic             emit, col_last, row_last, interior, value;

    assign pop  = !q_stat.empty && (!head.emit || !out_valid_reg || out_ready);
    assign emit = pop && head.emit;

    assign win_cur = head.update
                   ? (((window_reg << 1) & ROW_SHIFT_KEEP)
                      | {2'b00, head.stored[1], 2'b00, head.stored[0], 2'b00, head.px})
                   : window_reg;
    assign window_next = pop ? win_cur : window_reg;

    assign mask  = shape_mask(shape);
    assign sel   = win_cur & mask;
    assign value = (op == OP_ERODE) ? (sel == mask) : (sel != '0);

    assign col_last = (CMP_W'(out_col_reg) + CMP_W'(1)) >= CMP_W'(eff_width);
    assign row_last = (CMP_W'(out_row_reg) + CMP_W'(1)) >= CMP_W'(eff_height);
    // Interior excludes the first and last rows and columns.
    assign interior = (out_row_reg != '0) && !row_last
                   && ((CMP_W'(out_row_reg) + CMP_W'(2)) <= CMP_W'(eff_height))
                   && (out_col_reg != '0)
                   && ((CMP_W'(out_col_reg) + CMP_W'(2)) <= CMP_W'(eff_width));

    always_comb
    begin
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (col_last)
            begin
                out_col_next = '0;
                out_row_next = row_last ? '0 : out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_pixel_reg <= interior && value;
            out_last_reg  <= row_last && col_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

### src/binary_morphology_3x3.sv
// ============================================================================
// binary_morphology_3x3
// Streaming 3x3 binary erosion and dilation with selectable structuring element.
// ============================================================================
// Throughput is one beat per clock in both directions unless the queue is full
// or the output stalls; the line store has one read and one write port, each
// used at most once per beat. A result passes the front register, the queue and
// the output register; in stream terms the output trails the input by frame_width + 1 pixels.
// Reset puts the registers at 640 x 480, eight-neighbourhood erosion, and clears
// positions, window and queue; the line store is not cleared and needs none.
`default_nettype none

module binary_morphology_3x3
    import bm3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [0] pixel_in, [7:1] zero
    input  wire logic                   s_tuser,   // [0] action (1 = flush beat)
    // Output stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // [0] pixel_out, [7:1] zero
    output logic                        m_tlast,   // frame_end
    // Configuration write channel.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    // Configuration registers. Writes must come only while the stream is idle;
    // the block itself does not enforce this, and writes are always taken.
    logic [CFG_W-1:0] width_reg, height_reg;
    kernel_shape_t    shape_reg;
    operation_t       op_reg;
    logic [CFG_W-1:0] eff_width, eff_height;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            shape_reg  <= SHAPE_EIGHT;
            op_reg     <= OP_ERODE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                REG_KERNEL_SHAPE: shape_reg  <= kernel_shape_t'(cfg_data[SHAPE_W-1:0]);
                REG_OPERATION:    op_reg     <= operation_t'(cfg_data[0]);
                default:          ;
            endcase
        end
    end

    // The frame size in use is clamped to 3 .. MAX_WIDTH and 3 .. MAX_HEIGHT.
    always_comb
    begin
        if (width_reg < MIN_FRAME_DIM)
        begin
            eff_width = MIN_FRAME_DIM;
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            eff_width = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_reg;
        end

        if (height_reg < MIN_FRAME_DIM)
        begin
            eff_height = MIN_FRAME_DIM;
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            eff_height = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_height = height_reg;
        end
    end

    // The front decides, per beat, whether it shifts the window, produces
    // an output, or both; flush beats that owe nothing are dropped there.
    bm3_entry_t q_entry, q_head;
    bm3_qstat_t q_stat;
    logic       q_push, q_pop;
    logic       out_pixel;

    bm3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (action_t'(s_tuser)),
        .in_pixel   (s_tdata[0]),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    bm3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_entry),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // The back owns the window and the output register, so a stalled output
    // only holds entries that must produce a result.
    bm3_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_stat     (q_stat),
        .pop        (q_pop),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .shape      (shape_reg),
        .op         (op_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixel  (out_pixel),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'b0000000, out_pixel};

    // The queue never reports full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_stat.full && q_stat.empty))
        else $error("queue status reports full and empty together");

    // The front only pushes into a queue with room.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("push into a full queue");

    // The back only pops a queue that holds an entry.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire
